@@ hdl/grc_pkg.sv @@
// Shared types, register codes and the direction wave table for the column ray caster.
package grc_pkg;

   // Register indices on the configuration port
   localparam logic [1:0] CSR_MAP_LOW    = 2'd0;
   localparam logic [1:0] CSR_MAP_HIGH   = 2'd1;
   localparam logic [1:0] CSR_STEP_LIMIT = 2'd2;

   localparam logic [7:0] STEP_LIMIT_RESET = 8'd160;

   // Piecewise-linear quarter wave: pairs of (base, slope) per 16-unit segment
   localparam logic [6:0] WAVE_SEG [8] = '{7'd0, 7'd49, 7'd49, 7'd41,
                                           7'd90, 7'd27, 7'd117, 7'd10};

   // Result of one march, handed from the march unit to the sequencer
   typedef struct packed {
      logic       done;
      logic       hit;
      logic [7:0] count;
   } march_res_type;

   // Direction component for an angle: {sign, magnitude in 1/128}
   function automatic logic [7:0] wave_dir(input logic [7:0] a);
      logic [5:0]  off;
      logic [4:0]  sec;
      logic [1:0]  seg;
      logic [6:0]  base;
      logic [6:0]  slope;
      logic [11:0] prod;
      logic [6:0]  mag;
      off   = a[6] ? ~a[5:0] : a[5:0];
      sec   = {1'b0, off[3:0]} + {4'b0, a[6]};
      seg   = off[5:4];
      base  = WAVE_SEG[{seg, 1'b0}];
      slope = WAVE_SEG[{seg, 1'b1}];
      prod  = 12'(slope) * 12'(sec);
      mag   = 7'({1'b0, base} + {1'b0, prod[10:4]});
      return {a[7], mag};
   endfunction

endpackage

@@ hdl/grc_march.sv @@
// Fixed-step ray march: one step of both axes per cycle, each axis with its own step logic.
module grc_march
   import grc_pkg::*;
#(
   parameter int MAP_W = 16,
   parameter int MAP_H = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [11:0]   player_x,
   input  logic [10:0]   player_y,
   input  logic [7:0]    ray_angle,
   input  logic [7:0]    limit,
   input  logic [63:0]   map_low,
   input  logic [63:0]   map_high,
   output march_res_type res
);

   localparam logic signed [14:0] X_END = 15'(MAP_W * 256);
   localparam logic signed [14:0] Y_END = 15'(MAP_H * 256);
   localparam logic signed [14:0] NEG_END = -15'sd256;

   logic        busy_ff, busy_in;
   logic [11:0] base_x_ff;
   logic [10:0] base_y_ff;
   logic        neg_x_ff, neg_y_ff;
   logic [4:0]  qs_x_ff, qs_y_ff;
   logic [2:0]  rs_x_ff, rs_y_ff;
   logic [12:0] q_x_ff, q_x_in, q_y_ff, q_y_in;
   logic [2:0]  r_x_ff, r_x_in, r_y_ff, r_y_in;
   logic [7:0]  k_ff, k_in;
   logic [7:0]  limit_ff;
   logic        done_ff, done_in, hit_ff, hit_in;
   logic [7:0]  count_ff, count_in;

   // Start-of-ray values
   logic [7:0]  dir_x, dir_y;
   logic [14:0] div_x, div_y;
   logic [4:0]  q5_x, q5_y;
   logic [6:0]  r5_x, r5_y;

   // Step unit
   logic [3:0]  rsum_x, rsum_y;
   logic        cy_x, cy_y;
   logic signed [14:0] pos_x, pos_y;
   logic        out_map, wall;
   logic [3:0]  cell_x;
   logic [2:0]  cell_y;
   logic [5:0]  bit_idx;

   always_comb begin
      dir_x = wave_dir(ray_angle);
      dir_y = wave_dir(ray_angle + 8'd64);
      // divide by five: multiply by 205/1024, exact for 7-bit values
      div_x = 15'(dir_x[6:0]) * 15'd205;
      div_y = 15'(dir_y[6:0]) * 15'd205;
      q5_x  = div_x[14:10];
      q5_y  = div_y[14:10];
      r5_x  = dir_x[6:0] - 7'(q5_x) * 7'd5;
      r5_y  = dir_y[6:0] - 7'(q5_y) * 7'd5;
   end

   always_comb begin
      rsum_x = {1'b0, r_x_ff} + {1'b0, rs_x_ff};
      rsum_y = {1'b0, r_y_ff} + {1'b0, rs_y_ff};
      cy_x   = rsum_x >= 4'd5;
      cy_y   = rsum_y >= 4'd5;
      r_x_in = cy_x ? 3'(rsum_x - 4'd5) : rsum_x[2:0];
      r_y_in = cy_y ? 3'(rsum_y - 4'd5) : rsum_y[2:0];
      q_x_in = q_x_ff + 13'(qs_x_ff) + 13'(cy_x);
      q_y_in = q_y_ff + 13'(qs_y_ff) + 13'(cy_y);
      k_in   = k_ff + 8'd1;

      // offsets truncate toward zero, so a negative direction subtracts the magnitude
      pos_x = neg_x_ff ? $signed(15'(base_x_ff)) - $signed(15'(q_x_in))
                       : $signed(15'(base_x_ff)) + $signed(15'(q_x_in));
      pos_y = neg_y_ff ? $signed(15'(base_y_ff)) - $signed(15'(q_y_in))
                       : $signed(15'(base_y_ff)) + $signed(15'(q_y_in));

      // a position in (-1, 0) cell still lies in cell 0
      out_map = (pos_x <= NEG_END) || (pos_x >= X_END) ||
                (pos_y <= NEG_END) || (pos_y >= Y_END);
      cell_x  = pos_x[14] ? 4'd0 : pos_x[11:8];
      cell_y  = pos_y[14] ? 3'd0 : pos_y[10:8];
      bit_idx = {cell_x[2:0], cell_y};
      wall    = cell_x[3] ? map_high[bit_idx] : map_low[bit_idx];
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      hit_in   = hit_ff;
      count_in = count_ff;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (out_map) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            hit_in   = 1'b1;
            count_in = limit_ff;
         end else if (wall) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            hit_in   = 1'b1;
            count_in = k_in;
         end else if (k_in == limit_ff) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            hit_in   = 1'b0;
            count_in = k_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff   <= hit_in;
      count_ff <= count_in;
      if (start) begin
         base_x_ff <= player_x;
         base_y_ff <= player_y;
         neg_x_ff  <= dir_x[7];
         neg_y_ff  <= dir_y[7];
         qs_x_ff   <= q5_x;
         qs_y_ff   <= q5_y;
         rs_x_ff   <= r5_x[2:0];
         rs_y_ff   <= r5_y[2:0];
         q_x_ff    <= '0;
         q_y_ff    <= '0;
         r_x_ff    <= '0;
         r_y_ff    <= '0;
         k_ff      <= '0;
         limit_ff  <= limit;
      end else if (busy_ff) begin
         q_x_ff <= q_x_in;
         q_y_ff <= q_y_in;
         r_x_ff <= r_x_in;
         r_y_ff <= r_y_in;
         k_ff   <= k_in;
      end
   end

   assign res = '{done: done_ff, hit: hit_ff, count: count_ff};

endmodule

@@ hdl/grc_div.sv @@
// Restoring divider, one quotient bit per cycle, for the wall height.
module grc_div #(
   parameter int NUM_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [7:0]       divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic             rem_nz
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [7:0]       rem_ff, rem_in;
   logic [7:0]       dsr_ff;
   logic [8:0]       shifted, diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      ge      = shifted >= {1'b0, dsr_ff};
      rem_in  = ge ? diff[7:0] : shifted[7:0];
      quo_in  = {quo_ff[NUM_W-2:0], ge};
      cnt_in  = cnt_ff - CNT_W'(1);
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
         cnt_ff <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign rem_nz   = rem_ff != 8'd0;

endmodule

@@ hdl/grid_raycast_column.sv @@
// Top level of the column ray caster: sequencer, registers, wall height and shade.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  player_x, player_y, ray_angle
//   rsp      out        rsp_valid / rsp_stall  wall_hit, step_count, ceiling_row,
//                                              floor_row, wall_shade
//   csr      in         csr_write              csr_index, csr_data
//
// A transaction marches k steps (at most step_limit, or one when it is zero): the
// march unit walks one step per cycle, then the divider gives one quotient bit
// per cycle.
// Synchronous active-high reset clears the map to empty and the step limit to 160.
// req_stall is high from acceptance until the result moves into the output register;
// a result waiting on rsp_stall does not block the next request.
module grid_raycast_column
   import grc_pkg::*;
#(
   parameter int MAP_W    = 16,
   parameter int MAP_H    = 8,
   parameter int SCREEN_H = 320
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [11:0]       req_player_x,
   input  logic [10:0]       req_player_y,
   input  logic [7:0]        req_ray_angle,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_wall_hit,
   output logic [7:0]        rsp_step_count,
   output logic signed [8:0] rsp_ceiling_row,
   output logic [8:0]        rsp_floor_row,
   output logic [7:0]        rsp_wall_shade,
   // configuration port
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_data
);

   // Wall height: ceiling = SCREEN_H/2 - (5*SCREEN_H)/k
   localparam int HALF  = SCREEN_H / 2;
   localparam int N_NUM = 5 * SCREEN_H;
   localparam int NUM_W = $clog2(N_NUM + 1);
   localparam int CW    = NUM_W + 2;
   localparam int PW    = NUM_W + 9;

   localparam logic [PW-1:0]        N_P      = PW'(N_NUM);
   localparam logic [PW-1:0]        HALF_P   = PW'(HALF);
   localparam logic signed [CW-1:0] HALF_C   = CW'(HALF);
   localparam logic signed [CW-1:0] SCREEN_C = CW'(SCREEN_H);
   localparam logic signed [CW-1:0] MINUS1_C = -CW'(1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MARCH = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [63:0] map_low_ff, map_high_ff;
   logic [7:0]  step_limit_ff;
   logic [7:0]  limit_eff;

   // March result held for the height and shade stage
   logic        hit_ff;
   logic [7:0]  count_ff;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff;
   logic [7:0]        rsp_count_ff;
   logic signed [8:0] rsp_ceil_ff;
   logic [8:0]        rsp_floor_ff;
   logic [7:0]        rsp_shade_ff;

   logic          req_take, rsp_take, rsp_load;
   march_res_type march_res;
   logic             div_done, div_rem_nz;
   logic [NUM_W-1:0] div_quo;

   logic                ceil_sel;
   logic [NUM_W:0]      q_adj;
   logic signed [CW-1:0] c_raw, c_sat, floor_val;
   logic [9:0]          tri_count;
   logic [7:0]          shade;

   assign req_stall = state_ff != ST_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   // Zero step limit behaves as a limit of one
   assign limit_eff = (step_limit_ff == 8'd0) ? 8'd1 : step_limit_ff;

   // Configuration writes; unknown indices are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         map_low_ff    <= '0;
         map_high_ff   <= '0;
         step_limit_ff <= STEP_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAP_LOW:    map_low_ff    <= csr_data;
            CSR_MAP_HIGH:   map_high_ff   <= csr_data;
            CSR_STEP_LIMIT: step_limit_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   grc_march #(
      .MAP_W (MAP_W),
      .MAP_H (MAP_H)
   ) u_march (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .player_x  (req_player_x),
      .player_y  (req_player_y),
      .ray_angle (req_ray_angle),
      .limit     (limit_eff),
      .map_low   (map_low_ff),
      .map_high  (map_high_ff),
      .res       (march_res)
   );

   // The divider starts on the cycle the march finishes, with the step count as divisor
   grc_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (march_res.done),
      .dividend (NUM_W'(N_NUM)),
      .divisor  (march_res.count),
      .done     (div_done),
      .quotient (div_quo),
      .rem_nz   (div_rem_nz)
   );

   // Height: round the quotient up when the wall is at most the half screen,
   // i.e. when n <= half * k, otherwise down; floor the result at -1
   always_comb begin
      ceil_sel  = N_P <= HALF_P * PW'(count_ff);
      q_adj     = {1'b0, div_quo} + (NUM_W + 1)'(ceil_sel && div_rem_nz);
      c_raw     = HALF_C - $signed({1'b0, q_adj});
      c_sat     = (c_raw < MINUS1_C) ? MINUS1_C : c_raw;
      floor_val = SCREEN_C - c_sat;
      // shade = (510 - 3k) / 2, clamped at zero
      tri_count = {1'b0, count_ff, 1'b0} + 10'(count_ff);
      shade     = (tri_count < 10'd510) ? 8'((10'd510 - tri_count) >> 1) : 8'd0;
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_MARCH;
         end
         ST_MARCH: begin
            if (march_res.done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free or being emptied
            if (!rsp_valid_ff || rsp_take) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (march_res.done) begin
         hit_ff   <= march_res.hit;
         count_ff <= march_res.count;
      end
      if (rsp_load) begin
         rsp_hit_ff   <= hit_ff;
         rsp_count_ff <= count_ff;
         rsp_ceil_ff  <= c_sat[8:0];
         rsp_floor_ff <= floor_val[8:0];
         rsp_shade_ff <= shade;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wall_hit    = rsp_hit_ff;
   assign rsp_step_count  = rsp_count_ff;
   assign rsp_ceiling_row = rsp_ceil_ff;
   assign rsp_floor_row   = rsp_floor_ff;
   assign rsp_wall_shade  = rsp_shade_ff;

`ifndef NO_ASSERTIONS
   // A new result appears only out of the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside completion state");

   // The march unit reports only while the sequencer waits for it
   a_march_in_state: assert property (@(posedge clock) disable iff (reset)
      march_res.done |-> state_ff == ST_MARCH)
      else $error("march finished outside march state");

   // A delivered result never carries a zero step count
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_count_ff != 8'd0)
      else $error("zero step count delivered");

   // Ceiling and floor rows add up to the screen height, modulo the field width
   a_rows_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 9'(rsp_ceil_ff + rsp_floor_ff) == 9'(SCREEN_H))
      else $error("ceiling and floor rows inconsistent");
`endif

endmodule

@@ sim/tb_grid_raycast_column.sv @@
// Self-checking testbench for the column ray caster: directed and random rays over many maps.
module tb_grid_raycast_column
   import grc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int      MAP_W       = 16;
   localparam int      MAP_H       = 8;
   localparam int      SCREEN_H    = 320;
   localparam realtime CLK_PERIOD  = 10.0;
   localparam int      RESET_LEN   = 7;
   // Worst transaction is about 255 march steps plus the divider; settle for longer
   localparam int      SETTLE_LEN  = 400;
   localparam int      CYCLE_LIMIT = 2_000_000;
   localparam int      RAND_PHASES = 13;

   // The block ignores writes to the one index it does not decode
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   // Quarter-wave knees: base and slope per 16-unit segment of the angle
   localparam int SLOPE_TABLE [8] = '{0, 49, 49, 41, 90, 27, 117, 10};

   typedef struct {
      logic [11:0] player_x;
      logic [10:0] player_y;
      logic [7:0]  ray_angle;
   } ray_type;

   typedef struct {
      logic              wall_hit;
      logic [7:0]        step_count;
      logic signed [8:0] ceiling_row;
      logic [8:0]        floor_row;
      logic [7:0]        wall_shade;
   } column_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [11:0]       req_player_x = '0;
   logic [10:0]       req_player_y = '0;
   logic [7:0]        req_ray_angle = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_wall_hit;
   logic [7:0]        rsp_step_count;
   logic signed [8:0] rsp_ceiling_row;
   logic [8:0]        rsp_floor_row;
   logic [7:0]        rsp_wall_shade;
   logic              csr_write = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [63:0]       csr_data = '0;

   // Shadow of the register file, updated only while the block is idle
   logic [63:0] walls_lo;
   logic [63:0] walls_hi;
   logic [7:0]  march_limit;

   ray_type    rays_to_cast[$];
   column_type columns_due[$];
   ray_type    next_ray;
   column_type due_column;

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count = 0;
   int cycle_count;

   grid_raycast_column #(
      .MAP_W    (MAP_W),
      .MAP_H    (MAP_H),
      .SCREEN_H (SCREEN_H)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_player_x    (req_player_x),
      .req_player_y    (req_player_y),
      .req_ray_angle   (req_ray_angle),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_wall_hit    (rsp_wall_hit),
      .rsp_step_count  (rsp_step_count),
      .rsp_ceiling_row (rsp_ceiling_row),
      .rsp_floor_row   (rsp_floor_row),
      .rsp_wall_shade  (rsp_wall_shade),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Signed direction component in 1/128 for an angle of 256 units per turn.
   // Bit 6 mirrors the quarter and nudges the segment offset by one; bit 7 flips the sign.
   function automatic int wave_component(input int a);
      int off;
      int sec;
      int seg;
      int mag;
      off = a & 8'hFF;
      if (a & 8'h40) off = 255 - off;
      off = off & 8'h3F;
      sec = off & 4'hF;
      if (a & 8'h40) sec++;
      seg = (off >> 4) & 3;
      mag = SLOPE_TABLE[2 * seg] + ((SLOPE_TABLE[2 * seg + 1] * sec) >> 4);
      return (a & 8'h80) ? -mag : mag;
   endfunction

   function automatic bit wall_at(input int cx, input int cy);
      if (cx < 8) begin
         return walls_lo[(cx * 8 + cy) & 63];
      end
      return walls_hi[((cx - 8) * 8 + cy) & 63];
   endfunction

   // March one column through the shadow map and derive the wall slice from the distance
   function automatic column_type cast_column(input ray_type r);
      column_type res;
      int      px;
      int      py;
      int      dx;
      int      dy;
      int      lim;
      int      k;
      int      cx;
      int      cy;
      int      half;
      int      span;
      int      ceil_r;
      int      floor_r;
      int      shade;
      bit      hit;
      px   = int'(r.player_x);
      py   = int'(r.player_y);
      dx   = wave_component(int'(r.ray_angle));
      dy   = wave_component((int'(r.ray_angle) + 64) & 8'hFF);
      lim  = (march_limit == 0) ? 1 : int'(march_limit);
      k    = 0;
      hit  = 1'b0;
      while (!hit && k < lim) begin
         k++;
         // int division truncates toward zero, so a position just below zero stays in cell 0
         cx = (px + (dx * k) / 5) / 256;
         cy = (py + (dy * k) / 5) / 256;
         if (cx < 0 || cx >= MAP_W || cy < 0 || cy >= MAP_H) begin
            // leaving the map counts as a hit at the full view depth
            hit = 1'b1;
            k   = lim;
         end else if (wall_at(cx, cy)) begin
            hit = 1'b1;
         end
      end
      half = SCREEN_H / 2;
      span = 5 * SCREEN_H;
      if (span <= half * k) begin
         ceil_r = half - (span + k - 1) / k;
      end else begin
         ceil_r = half - span / k;
      end
      if (ceil_r < -1) ceil_r = -1;
      floor_r = SCREEN_H - ceil_r;
      shade   = (3 * k < 510) ? (510 - 3 * k) / 2 : 0;
      res.wall_hit    = hit;
      res.step_count  = 8'(k);
      res.ceiling_row = 9'(ceil_r);
      res.floor_row   = 9'(floor_r);
      res.wall_shade  = 8'(shade);
      return res;
   endfunction

   // Request driver: advance to the next queued ray once the current one is taken,
   // or drop valid for an idle cycle at the configured rate
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            next_ray.player_x  = req_player_x;
            next_ray.player_y  = req_player_y;
            next_ray.ray_angle = req_ray_angle;
            columns_due.push_back(cast_column(next_ray));
         end
         if (!req_valid || !req_stall) begin
            if (rays_to_cast.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_ray = rays_to_cast.pop_front();
               req_player_x  <= next_ray.player_x;
               req_player_y  <= next_ray.player_y;
               req_ray_angle <= next_ray.ray_angle;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         // a stalled transaction holds valid and payload untouched
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t column mismatch (%s): exp hit=%0d steps=%0d ceil=%0d floor=%0d shade=%0d",
                  $realtime, what, due_column.wall_hit, due_column.step_count,
                  due_column.ceiling_row, due_column.floor_row, due_column.wall_shade);
         $display("%0t                         got hit=%0d steps=%0d ceil=%0d floor=%0d shade=%0d",
                  $realtime, rsp_wall_hit, rsp_step_count, rsp_ceiling_row, rsp_floor_row,
                  rsp_wall_shade);
      end
   endtask

   // Response monitor: stall at random and check each transaction against the oldest
   // predicted column
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (columns_due.size() == 0) begin
               due_column = '{default: 'x};
               report_mismatch("no column outstanding");
            end else begin
               due_column = columns_due.pop_front();
               if (rsp_wall_hit !== due_column.wall_hit ||
                   rsp_step_count !== due_column.step_count ||
                   rsp_ceiling_row !== due_column.ceiling_row ||
                   rsp_floor_row !== due_column.floor_row ||
                   rsp_wall_shade !== due_column.wall_shade) begin
                  report_mismatch("field differs");
               end
            end
         end
      end
   end

   // Write one register; the shadow follows at once since the bench writes only while idle
   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         CSR_MAP_LOW:    walls_lo    = value;
         CSR_MAP_HIGH:   walls_hi    = value;
         CSR_STEP_LIMIT: march_limit = value[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic queue_ray(input int px, input int py, input int ang);
      ray_type r;
      r.player_x  = 12'(px);
      r.player_y  = 11'(py);
      r.ray_angle = 8'(ang);
      rays_to_cast.push_back(r);
   endtask

   // Hold until every queued ray is taken and every column has come back
   task automatic drain();
      while (rays_to_cast.size() > 0 || req_valid || columns_due.size() > 0) begin
         @(negedge clock);
      end
   endtask

   function automatic logic [63:0] random_walls(input int pct);
      logic [63:0] w;
      for (int i = 0; i < 64; i++) begin
         w[i] = ($urandom_range(99) < pct);
      end
      return w;
   endfunction

   initial begin
      int density [5];
      int limit_val;
      int n_rays;
      int px;
      int py;
      density = '{0, 5, 15, 40, 100};
      reset         = 1'b1;
      walls_lo      = '0;
      walls_hi      = '0;
      march_limit   = STEP_LIMIT_RESET;
      send_idle_pct = 27;
      recv_idle_pct = 88;
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      // Empty map, reset step limit: corners of the field ranges, the four axis
      // directions, a diagonal, a ray that runs out of steps, and one that dips just
      // below zero on x before it leaves the map
      queue_ray(0, 0, 0);
      queue_ray(4095, 2047, 255);
      queue_ray(128, 128, 64);
      queue_ray(2048, 1024, 128);
      queue_ray(2048, 1024, 192);
      queue_ray(2048, 1024, 32);
      queue_ray(0, 1024, 64);
      queue_ray(50, 100, 192);
      drain();

      // Left half solid: a ray that starts inside a wall, and one that walks into it
      write_reg(CSR_MAP_LOW, '1);
      queue_ray(256, 256, 64);
      queue_ray(3000, 512, 192);
      queue_ray(0, 0, 128);
      drain();

      // Zero step limit behaves as a limit of one
      write_reg(CSR_STEP_LIMIT, 64'd0);
      queue_ray(2048, 1024, 64);
      queue_ray(3000, 512, 96);
      drain();

      // Widest step limit; right half solid; unmapped index must be ignored
      write_reg(CSR_STEP_LIMIT, 64'd255);
      write_reg(CSR_MAP_LOW, '0);
      write_reg(CSR_MAP_HIGH, '1);
      write_reg(CSR_UNMAPPED, '1);
      queue_ray(100, 100, 64);
      queue_ray(100, 1800, 0);
      queue_ray(1000, 20, 160);
      drain();

      // Narrowest step limit: one ray leaves the map on the very first step, one runs out of steps
      write_reg(CSR_STEP_LIMIT, 64'd1);
      queue_ray(4095, 2047, 64);
      queue_ray(10, 10, 200);
      drain();

      // Random phases, each with fresh walls and step limit; swap the idle pattern
      // part-way, then finish with both sides streaming
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         if (phase == 4) begin
            send_idle_pct = 88;
            recv_idle_pct = 27;
         end else if (phase == 9) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase % 6)
            0:       limit_val = 255;
            2:       limit_val = 1;
            4:       limit_val = 0;
            default: limit_val = $urandom_range(1, 255);
         endcase
         write_reg(CSR_MAP_LOW, random_walls(density[$urandom_range(4)]));
         write_reg(CSR_MAP_HIGH, random_walls(density[$urandom_range(4)]));
         write_reg(CSR_STEP_LIMIT, 64'(limit_val));
         if ($urandom_range(3) == 0) write_reg(CSR_UNMAPPED, {$urandom, $urandom});
         // one-step limits give little to march through, so keep those phases short
         n_rays = (limit_val <= 1) ? 10 : 65;
         for (int i = 0; i < n_rays; i++) begin
            px = $urandom_range(4095);
            py = $urandom_range(2047);
            // now and then start hard against an edge so the ray crosses zero or the rim
            case ($urandom_range(7))
               0:       px = $urandom_range(63);
               1:       py = $urandom_range(63);
               2:       px = $urandom_range(4032, 4095);
               3:       py = $urandom_range(1984, 2047);
               default: ;
            endcase
            queue_ray(px, py, $urandom_range(255));
         end
         drain();
      end

      // Let any stray transaction surface before judging
      repeat (SETTLE_LEN) @(posedge clock);
      mismatch_count += columns_due.size();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: end the run if the block stops answering
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule

@@ grid_raycast_column.f @@
hdl/grc_pkg.sv
hdl/grc_march.sv
hdl/grc_div.sv
hdl/grid_raycast_column.sv
sim/tb_grid_raycast_column.sv
